// ===== design/sud_pkg.sv =====
package sud_pkg;

	localparam int DATA_WIDTH = 64;
	localparam int CNT_W = $clog2(DATA_WIDTH);

	typedef logic [DATA_WIDTH-1:0] word_t;
	typedef logic [CNT_W-1:0] cnt_t;

	localparam logic [1:0] MODE_UQUO = 2'd0;
	localparam logic [1:0] MODE_UREM = 2'd1;
	localparam logic [1:0] MODE_SQUO = 2'd2;
	localparam logic [1:0] MODE_SREM = 2'd3;

	// Result of one restoring step of the shared unit.
	typedef struct packed {
		word_t rem;
		logic  quo_bit;
	} step_t;

	function automatic word_t negate(word_t v);
		return ~v + word_t'(1);
	endfunction

	function automatic logic is_signed_mode(logic [1:0] m);
		return (m == MODE_SQUO) || (m == MODE_SREM);
	endfunction

endpackage

// ===== design/signed_unsigned_divider_64_top.sv =====
// Restoring integer divider for 64-bit operands. mode selects unsigned
// quotient, unsigned remainder, signed quotient or signed remainder; signed
// modes divide magnitudes and fix the sign at the end, so the quotient
// truncates toward zero and the remainder follows the dividend's sign. A
// zero divisor gives answer 0 with divide_by_zero set. One compare-subtract
// unit produces one quotient bit per cycle. An accepted transaction loads the
// magnitudes, runs 64 iterations of the shared step, and then fixes the sign
// into the output register once that register is free. A zero divisor skips
// the iterations. in_stall is high while a division is in progress; the
// output register lets a new transaction start while the previous result
// still waits to be taken.
module signed_unsigned_divider_64_top (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     mode,
	input  sud_pkg::word_t dividend,
	input  sud_pkg::word_t divisor,
	output logic           out_valid,
	input  logic           out_stall,
	output sud_pkg::word_t answer,
	output logic           divide_by_zero
);
	import sud_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_FIX  = 2'd2;

	logic [1:0] state_q;
	cnt_t       cnt_q;
	word_t      quo_q;
	word_t      rem_q;
	word_t      den_q;
	logic [1:0] mode_q;
	logic       nneg_q;
	logic       dneg_q;
	logic       dbz_q;

	logic       out_valid_q;
	word_t      answer_q;
	logic       dbz_out_q;

	logic       in_acc;
	logic       out_free;
	logic       smode;
	logic       nneg;
	logic       dneg;
	step_t      step;
	word_t      sel;
	logic       neg_res;
	word_t      fixed;

	sud_step u_step (
		.rem_in  (rem_q),
		.num_bit (quo_q[DATA_WIDTH-1]),
		.den     (den_q),
		.step    (step)
	);

	assign in_stall = (state_q != ST_IDLE);
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;

	assign smode = is_signed_mode(mode);
	assign nneg = smode && dividend[DATA_WIDTH-1];
	assign dneg = smode && divisor[DATA_WIDTH-1];

	always_comb begin
		sel = (mode_q == MODE_UREM || mode_q == MODE_SREM) ? rem_q : quo_q;
		unique case (mode_q)
			MODE_SQUO: neg_res = nneg_q ^ dneg_q;
			MODE_SREM: neg_res = nneg_q;
			default:   neg_res = 1'b0;
		endcase
		if (dbz_q) begin
			fixed = '0;
		end else if (neg_res) begin
			fixed = negate(sel);
		end else begin
			fixed = sel;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						state_q <= (divisor == '0) ? ST_FIX : ST_DIV;
						cnt_q <= '0;
					end
				end
				ST_DIV: begin
					cnt_q <= cnt_q + cnt_t'(1);
					if (cnt_q == cnt_t'(DATA_WIDTH - 1)) begin
						state_q <= ST_FIX;
					end
				end
				ST_FIX: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (state_q == ST_FIX && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			quo_q <= nneg ? negate(dividend) : dividend;
			den_q <= dneg ? negate(divisor) : divisor;
			rem_q <= '0;
			mode_q <= mode;
			nneg_q <= nneg;
			dneg_q <= dneg;
			dbz_q <= (divisor == '0);
		end else if (state_q == ST_DIV) begin
			quo_q <= {quo_q[DATA_WIDTH-2:0], step.quo_bit};
			rem_q <= step.rem;
		end
		if (state_q == ST_FIX && out_free) begin
			answer_q <= fixed;
			dbz_out_q <= dbz_q;
		end
	end

	assign out_valid = out_valid_q;
	assign answer = answer_q;
	assign divide_by_zero = dbz_out_q;

	a_dbz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> answer == '0)
		else $error("divide by zero result carries a nonzero answer");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> in_stall)
		else $error("divider not busy after accepting a transaction");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && cnt_q == cnt_t'(DATA_WIDTH - 1) |=> state_q == ST_FIX)
		else $error("iteration count did not end the division");

	a_fix_loads: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIX && out_free |=> out_valid)
		else $error("finished result not loaded into the output register");

endmodule

// ===== design/sud_step.sv =====
module sud_step (
	input  sud_pkg::word_t rem_in,
	input  logic           num_bit,
	input  sud_pkg::word_t den,
	output sud_pkg::step_t step
);
	import sud_pkg::*;

	logic [DATA_WIDTH:0] rem_sh;
	logic [DATA_WIDTH:0] diff;
	logic                fits;

	// The partial remainder is below the divisor before the shift, so the
	// shifted value fits in one extra bit and one subtraction settles the bit.
	always_comb begin
		rem_sh = {rem_in, num_bit};
		diff = rem_sh - {1'b0, den};
		fits = ~diff[DATA_WIDTH];
		step.quo_bit = fits;
		step.rem = fits ? diff[DATA_WIDTH-1:0] : rem_sh[DATA_WIDTH-1:0];
	end

endmodule
